[hw/rtl/cfe_pkg.sv]
// cfe_pkg: shared constants for the command frame exchange block
// action codes, register indexes, port widths and reset values
// no dependencies
package cfe_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned ActionW  = 2;
   localparam int unsigned TicksW   = 16;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned CountW   = 2;

   typedef logic [ActionW-1:0]  action_type;
   typedef logic [CsrIdxW-1:0]  csr_idx_type;
   typedef logic [ByteW-1:0]    byte_type;
   typedef logic [TicksW-1:0]   ticks_type;
   typedef logic [CsrDataW-1:0] csr_data_type;
   typedef logic [CountW-1:0]   count_type;

   // input actions
   localparam action_type ACT_START = 2'd0;
   localparam action_type ACT_RX    = 2'd1;
   localparam action_type ACT_TICK  = 2'd2;

   // register indexes
   localparam csr_idx_type CSR_HEADER = 2'd0;
   localparam csr_idx_type CSR_RETRY  = 2'd1;

   // result kinds
   localparam logic KIND_TX  = 1'b0;
   localparam logic KIND_ACK = 1'b1;

   // words queued per result set
   localparam count_type CNT_NONE  = 2'd0;
   localparam count_type CNT_ONE   = 2'd1;
   localparam count_type CNT_FRAME = 2'd3;

   localparam ticks_type RETRY_RESET = 16'd5000;

endpackage

[hw/rtl/command_frame_exchange_top.sv]
// command_frame_exchange_top: three-byte command frame sender with echo check and retry
// depends on cfe_pkg
//
//   channel  | direction | handshake              | payload
//   req_     | in        | req_valid / req_ready  | action, cmd_code, rx_byte
//   rsp_     | out       | rsp_valid / rsp_ready  | kind, tx_data, last
//   csr_     | in        | csr_write              | csr_index, csr_wdata
//
// an input word is decoded in the cycle it is taken; its result words appear on rsp_ next cycle
// a frame is three words on rsp_, an acknowledge one, other input words none
// the next input word is taken while the last result word of the previous set is being taken
// reset is synchronous; a stall on rsp_ holds the queued words and back-pressures req_
module command_frame_exchange_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfe_pkg::action_type   req_action,
   input  cfe_pkg::byte_type     req_cmd_code,
   input  cfe_pkg::byte_type     req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output cfe_pkg::byte_type     rsp_tx_data,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  cfe_pkg::csr_idx_type  csr_index,
   input  cfe_pkg::csr_data_type csr_wdata
);
   import cfe_pkg::*;

   byte_type  header_ff, recent0_ff, recent1_ff, pending_ff;
   byte_type  recent0_in, recent1_in, pending_in;
   ticks_type retry_ff, tick_ff, tick_in;
   logic      waiting_ff, waiting_in;
   count_type cnt_ff, cnt_in;
   logic      kind_ff, kind_in;
   byte_type  data0_ff, data1_ff, data2_ff;
   byte_type  data0_in, data1_in, data2_in;

   logic      req_acc, rsp_acc;
   count_type load_n;
   logic      load_kind;
   byte_type  ld0, ld1, ld2;
   byte_type  start_sum, resend_sum, window_sum;

   assign req_acc   = req_valid & req_ready;
   assign rsp_acc   = rsp_valid & rsp_ready;
   assign req_ready = (cnt_ff == CNT_NONE) || ((cnt_ff == CNT_ONE) && rsp_ready);

   assign rsp_valid   = (cnt_ff != CNT_NONE);
   assign rsp_kind    = kind_ff;
   assign rsp_tx_data = data0_ff;
   assign rsp_last    = (cnt_ff == CNT_ONE);

   assign start_sum  = header_ff + req_cmd_code;
   assign resend_sum = header_ff + pending_ff;
   assign window_sum = recent0_ff + recent1_ff;

   // decode one input word and update exchange state
   always_comb begin
      recent0_in = recent0_ff;
      recent1_in = recent1_ff;
      pending_in = pending_ff;
      waiting_in = waiting_ff;
      tick_in    = tick_ff;
      load_n     = CNT_NONE;
      load_kind  = KIND_TX;
      ld0        = header_ff;
      ld1        = pending_ff;
      ld2        = resend_sum;
      if (req_acc) begin
         case (req_action)
            ACT_START: begin
               pending_in = req_cmd_code;
               waiting_in = 1'b1;
               tick_in    = retry_ff;
               load_n     = CNT_FRAME;
               ld1        = req_cmd_code;
               ld2        = start_sum;
            end
            ACT_RX: begin
               recent0_in = recent1_ff;
               recent1_in = req_rx_byte;
               // window: two stored bytes plus the new one
               if (waiting_ff && (recent0_ff == header_ff) && (req_rx_byte == window_sum)
                   && (recent1_ff == pending_ff)) begin
                  waiting_in = 1'b0;
                  load_n     = CNT_ONE;
                  load_kind  = KIND_ACK;
                  ld0        = recent1_ff;
               end
            end
            ACT_TICK: begin
               if (waiting_ff) begin
                  if (tick_ff == '0) begin
                     tick_in = retry_ff;
                     load_n  = CNT_FRAME;
                  end else begin
                     tick_in = tick_ff - 16'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result word queue, oldest word in data0
   always_comb begin
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      data0_in = data0_ff;
      data1_in = data1_ff;
      data2_in = data2_ff;
      if (load_n != CNT_NONE) begin
         cnt_in   = load_n;
         kind_in  = load_kind;
         data0_in = ld0;
         data1_in = ld1;
         data2_in = ld2;
      end else if (rsp_acc) begin
         cnt_in   = cnt_ff - CNT_ONE;
         data0_in = data1_ff;
         data1_in = data2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= '0;
         retry_ff   <= RETRY_RESET;
         recent0_ff <= '0;
         recent1_ff <= '0;
         pending_ff <= '0;
         waiting_ff <= 1'b0;
         tick_ff    <= RETRY_RESET;
         cnt_ff     <= CNT_NONE;
         kind_ff    <= KIND_TX;
      end else begin
         recent0_ff <= recent0_in;
         recent1_ff <= recent1_in;
         pending_ff <= pending_in;
         waiting_ff <= waiting_in;
         tick_ff    <= tick_in;
         cnt_ff     <= cnt_in;
         kind_ff    <= kind_in;
         if (csr_write) begin
            case (csr_index)
               CSR_HEADER: header_ff <= csr_wdata[ByteW-1:0];
               CSR_RETRY:  retry_ff  <= csr_wdata[TicksW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      data0_ff <= data0_in;
      data1_ff <= data1_in;
      data2_ff <= data2_in;
   end

endmodule

[hw/rtl/cfe_checker.sv]
// cfe_checker: port-level checks for command_frame_exchange_top, with its bind
// depends on cfe_pkg
module cfe_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input cfe_pkg::action_type  req_action,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_kind,
   input cfe_pkg::byte_type    rsp_tx_data,
   input logic                 rsp_last
);
   import cfe_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_data) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // an acknowledge is a one-word set
   a_ack_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last)
      else $error("acknowledge without last");

   // a start always opens a frame on the next cycle
   a_start_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_START)
      |=> rsp_valid && !rsp_kind && !rsp_last)
      else $error("start did not open a frame");

   // a frame continues once a middle word is taken
   a_frame_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && !rsp_kind)
      else $error("frame cut short");

   // no new input word while more than one result word is queued
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken over a pending frame");

endmodule

bind command_frame_exchange_top cfe_checker u_cfe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_action  (req_action),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_kind    (rsp_kind),
   .rsp_tx_data (rsp_tx_data),
   .rsp_last    (rsp_last)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for command_frame_exchange_top (frame send, echo ack, retry)
// depends on cfe_pkg and the block's rtl; an in-bench model predicts every rsp_ word
module tb_top;
   import cfe_pkg::*;

   localparam action_type  ACT_IGNORED   = 2'd3;
   localparam csr_idx_type CSR_UNUSED_LO = 2'd2;
   localparam csr_idx_type CSR_UNUSED_HI = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef struct packed {
      logic     kind;
      byte_type data;
      logic     last;
   } rsp_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   action_type   req_action = ACT_START;
   byte_type     req_cmd_code = '0;
   byte_type     req_rx_byte = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic         rsp_kind;
   byte_type     rsp_tx_data;
   logic         rsp_last;
   logic         csr_write = 1'b0;
   csr_idx_type  csr_index = CSR_HEADER;
   csr_data_type csr_wdata = '0;

   // model of the exchange
   byte_type  hdr_byte = '0;
   ticks_type retry_reload = RETRY_RESET;
   byte_type  win_bytes [2] = '{8'h00, 8'h00};
   byte_type  open_code = '0;
   logic      exchange_open = 1'b0;
   ticks_type ticks_left = RETRY_RESET;

   rsp_word_type due_words [$];
   int unsigned  mismatches = 0;
   logic         gaps_on = 1'b1;
   logic         stalls_on = 1'b1;

   command_frame_exchange_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_cmd_code (req_cmd_code),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_tx_data  (rsp_tx_data),
      .rsp_last     (rsp_last),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void queue_frame();
      due_words.push_back('{KIND_TX, hdr_byte, 1'b0});
      due_words.push_back('{KIND_TX, open_code, 1'b0});
      due_words.push_back('{KIND_TX, byte_type'(hdr_byte + open_code), 1'b1});
   endfunction

   function automatic void advance_exchange(input action_type act, input byte_type val);
      byte_type oldest;
      byte_type middle;
      logic     frame_ok;
      case (act)
         ACT_START: begin
            open_code     = val;
            exchange_open = 1'b1;
            ticks_left    = retry_reload;
            queue_frame();
         end
         ACT_RX: begin
            oldest       = win_bytes[0];
            middle       = win_bytes[1];
            win_bytes[0] = middle;
            win_bytes[1] = val;
            frame_ok = (oldest == hdr_byte) && (val == byte_type'(oldest + middle));
            if (exchange_open && frame_ok && middle == open_code) begin
               exchange_open = 1'b0;
               due_words.push_back('{KIND_ACK, middle, 1'b1});
            end
         end
         ACT_TICK: begin
            if (exchange_open) begin
               if (ticks_left == 0) begin
                  ticks_left = retry_reload;
                  queue_frame();
               end else begin
                  ticks_left = ticks_left - 1'b1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // every rsp_ word taken is checked against the oldest prediction
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            flag_error($sformatf("unexpected word kind=%0d data=%h last=%0d",
                                 rsp_kind, rsp_tx_data, rsp_last));
         end else begin
            want = due_words.pop_front();
            if (rsp_kind !== want.kind)
               flag_error($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_tx_data !== want.data)
               flag_error($sformatf("tx_data %h, want %h", rsp_tx_data, want.data));
            if (rsp_last !== want.last)
               flag_error($sformatf("last %0d, want %0d", rsp_last, want.last));
         end
      end
   end

   // receiver side: random stall before each word
   initial begin : drain_rsp
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         stall = stalls_on ? $urandom_range(0, 10) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_word(input action_type act, input byte_type val);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_cmd_code <= (act == ACT_START) ? val : byte_type'($urandom);
      req_rx_byte  <= (act == ACT_RX) ? val : byte_type'($urandom);
      do @(posedge clock); while (!req_ready);
      advance_exchange(act, val);
   endtask

   task automatic send_echo(input byte_type h, input byte_type code, input byte_type sum);
      send_word(ACT_RX, h);
      send_word(ACT_RX, code);
      send_word(ACT_RX, sum);
   endtask

   // wait for every predicted word, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_data_type data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_HEADER)
         hdr_byte = data[ByteW-1:0];
      else if (idx == CSR_RETRY)
         retry_reload = data;
      @(posedge clock);
   endtask

   // reset header and retry values: frame, echo ack, idle tick
   task automatic test_defaults();
      send_word(ACT_START, 8'h12);
      send_echo(8'h00, 8'h12, 8'h12);
      send_word(ACT_TICK, 8'h00);
      settle();
   endtask

   // all-ones header and code, resend on every tick, ignored action and registers
   task automatic test_edges();
      write_reg(CSR_HEADER, 16'hA5FF);
      write_reg(CSR_RETRY, 16'h0000);
      write_reg(CSR_UNUSED_LO, 16'hA5A5);
      write_reg(CSR_UNUSED_HI, 16'hFFFF);
      send_word(ACT_START, 8'hFF);
      send_word(ACT_TICK, 8'h00);
      send_word(ACT_IGNORED, 8'h00);
      send_echo(8'hFF, 8'h34, 8'h33);   // good frame, wrong code
      send_echo(8'hFF, 8'hFF, 8'hFE);
      send_word(ACT_RX, 8'h00);         // idle byte
      settle();
   endtask

   // frame completed by bytes seen before start, restart while open, tick countdown
   task automatic test_window_restart();
      write_reg(CSR_HEADER, 16'h005A);
      write_reg(CSR_RETRY, 16'd2);
      send_word(ACT_RX, 8'h5A);
      send_word(ACT_RX, 8'h80);
      send_word(ACT_START, 8'h80);
      send_word(ACT_RX, 8'hDA);
      send_word(ACT_START, 8'h01);
      send_word(ACT_START, 8'h7F);
      repeat (3) send_word(ACT_TICK, 8'h00);
      send_echo(8'h5A, 8'h7F, 8'hD9);
      send_word(ACT_TICK, 8'h00);
      settle();
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      byte_type    h;
      byte_type    code;
      byte_type    sum;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12 || (!exchange_open && pick < 50)) begin
            send_word(ACT_START, byte_type'($urandom));
            sent++;
         end else if (pick < 55) begin
            // echo of the open code, sometimes a wrong code or a broken frame
            h    = hdr_byte;
            code = ($urandom_range(0, 3) == 0) ? byte_type'($urandom) : open_code;
            sum  = h + code;
            case ($urandom_range(0, 7))
               0: h = h ^ byte_type'($urandom_range(1, 255));
               1: sum = sum ^ byte_type'($urandom_range(1, 255));
               default: ;
            endcase
            send_echo(h, code, sum);
            sent += 3;
         end else if (pick < 80) begin
            burst = $urandom_range(1, (retry_reload < 6) ? retry_reload + 2 : 4);
            repeat (burst) send_word(ACT_TICK, 8'h00);
            sent += burst;
         end else if (pick < 95) begin
            send_word(ACT_RX, byte_type'($urandom));
            sent++;
         end else begin
            send_word(ACT_IGNORED, byte_type'($urandom));
         end
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               write_reg(CSR_HEADER, 16'h0000);
               write_reg(CSR_RETRY, 16'd1);
               gaps_on   = 1'b0;
               stalls_on = 1'b0;
            end
            1: begin
               write_reg(CSR_HEADER, 16'h00FF);
               write_reg(CSR_RETRY, 16'hFFFF);
               gaps_on   = 1'b1;
               stalls_on = 1'b1;
            end
            2: begin
               write_reg(CSR_HEADER, csr_data_type'($urandom));
               write_reg(CSR_RETRY, 16'd0);
               gaps_on   = 1'b1;
               stalls_on = 1'b0;
            end
            3: begin
               write_reg(CSR_HEADER, csr_data_type'($urandom));
               write_reg(CSR_RETRY, csr_data_type'($urandom_range(2, 6)));
               gaps_on   = 1'b0;
               stalls_on = 1'b1;
            end
            default: begin
               write_reg(CSR_HEADER, csr_data_type'($urandom));
               write_reg(CSR_RETRY, 16'd3);
               gaps_on   = 1'b1;
               stalls_on = 1'b1;
            end
         endcase
         random_traffic(100);
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_edges();
      test_window_restart();
      test_random_phases();
      settle();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ERROR at %0t: run timed out", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
